// ===== rtl/metu_pkg.sv =====
package metu_pkg;

   localparam int COORD_FRAC_BITS = 28;
   localparam int LOG_TABLE_BITS  = 8;
   localparam int LOG_TABLE_SIZE  = 2 ** LOG_TABLE_BITS;
   localparam int SMOOTH_BIAS_Q16 = 165725;
   localparam int CSR_INDEX_W     = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_X_ORIGIN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_STEP   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_ORIGIN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_STEP   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT    = 3'd4;

   typedef struct packed {
      logic [11:0] column;
      logic [11:0] row;
   } req_type;

   typedef struct packed {
      logic [23:0] smooth_value;
      logic [15:0] escape_count;
      logic        in_set;
      logic        by_shortcut;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] x_origin;
      logic signed [31:0] x_step;
      logic signed [31:0] y_origin;
      logic signed [31:0] y_step;
      logic [15:0]        iteration_limit;
   } cfg_type;

   // one classified point handed from front to back
   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic               shortcut;
   } work_type;

   typedef logic [15:0] log_tab_type [LOG_TABLE_SIZE];

   // log2(1 + i / 2^LOG_TABLE_BITS) in Q.16, bit by bit through repeated squaring in Q2.30
   function automatic log_tab_type build_log_table();
      log_tab_type t;
      logic [63:0] y;
      logic [15:0] r;
      for (int i = 0; i < LOG_TABLE_SIZE; i++) begin
         y = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
         r = '0;
         for (int k = 0; k < 16; k++) begin
            y = (y * y) >> 30;
            r = r << 1;
            if (y >= (64'd2 << 30)) begin
               y = y >> 1;
               r = r | 16'd1;
            end
         end
         t[i] = r;
      end
      return t;
   endfunction

   localparam log_tab_type LOG_TABLE = build_log_table();

endpackage

// ===== rtl/metu_front.sv =====
module metu_front
   import metu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   output logic     push,
   output work_type push_data,
   input  logic     queue_full
);

   typedef enum logic [2:0] {F_IDLE, F_MUL, F_SAT, F_SQR, F_PART, F_PUSH} state_type;

   state_type          state_ff, state_in;
   logic [11:0]        col_ff, col_in, row_ff, row_in;
   logic signed [44:0] mx_ff, mx_in, my_ff, my_in;
   logic signed [31:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [32:0] sx_ff, sx_in;
   logic [37:0]        sx2_ff, sx2_in, bx2_ff, bx2_in, cy2_ff, cy2_in;
   logic [38:0]        q_ff, q_in;
   logic               qs_neg_ff, qs_neg_in, bulb_ff, bulb_in;
   logic [18:0]        qs_hi_ff, qs_hi_in;
   logic [58:0]        plo_ff, plo_in;

   logic signed [32:0] bx, cy33;
   logic [65:0]        sq_sx, sq_bx, sq_cy;
   logic [38:0]        q_c;
   logic signed [39:0] qs_c;
   logic [77:0]        prod;
   logic               card;

   function automatic logic signed [31:0] sat32(logic signed [31:0] o, logic signed [44:0] m);
      logic signed [45:0] s;
      s = {{14{o[31]}}, o} + {m[44], m};
      if (s > 46'sh7FFFFFFF) return 32'sh7FFFFFFF;
      if (s < -46'sh80000000) return 32'sh80000000;
      return s[31:0];
   endfunction

   function automatic logic [32:0] mag33(logic signed [32:0] v);
      return v[32] ? 33'(-v) : 33'(v);
   endfunction

   assign bx    = {cx_ff[31], cx_ff} + 33'sd268435456;
   assign cy33  = {cy_ff[31], cy_ff};
   assign sq_sx = 66'(mag33(sx_in)) * 66'(mag33(sx_in));
   assign sq_bx = 66'(mag33(bx)) * 66'(mag33(bx));
   assign sq_cy = 66'(mag33(cy33)) * 66'(mag33(cy33));
   assign q_c   = 39'(sx2_ff) + 39'(cy2_ff);
   assign qs_c  = $signed({1'b0, q_c}) + {{7{sx_ff[32]}}, sx_ff};
   assign prod  = 78'(plo_ff) + ((78'(q_ff) * 78'(qs_hi_ff)) << 20);
   assign card  = qs_neg_ff || (prod[77:28] <= 50'(cy2_ff >> 2));

   assign req_stall = (state_ff != F_IDLE);
   assign push      = (state_ff == F_PUSH) && !queue_full;
   assign push_data = '{cx: cx_ff, cy: cy_ff, shortcut: card || bulb_ff};

   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      mx_in     = $signed({1'b0, col_ff}) * cfg.x_step;
      my_in     = $signed({1'b0, row_ff}) * cfg.y_step;
      cx_in     = sat32(cfg.x_origin, mx_ff);
      cy_in     = sat32(cfg.y_origin, my_ff);
      sx_in     = {cx_ff[31], cx_ff} - 33'sd67108864;
      sx2_in    = sq_sx[65:28];
      bx2_in    = sq_bx[65:28];
      cy2_in    = sq_cy[65:28];
      q_in      = q_c;
      qs_neg_in = qs_c[39];
      qs_hi_in  = qs_c[38:20];
      plo_in    = 59'(q_c) * 59'(qs_c[19:0]);
      bulb_in   = (39'(bx2_ff) + 39'(cy2_ff)) <= 39'd16777216;
      unique case (state_ff)
         F_IDLE: if (req_valid) begin
            col_in   = req_data.column;
            row_in   = req_data.row;
            state_in = F_MUL;
         end
         F_MUL:  state_in = F_SAT;
         F_SAT:  state_in = F_SQR;
         F_SQR:  state_in = F_PART;
         F_PART: state_in = F_PUSH;
         F_PUSH: if (!queue_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      col_ff    <= col_in;
      row_ff    <= row_in;
      if (state_ff == F_MUL) begin
         mx_ff <= mx_in;
         my_ff <= my_in;
      end
      if (state_ff == F_SAT) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
      end
      if (state_ff == F_SQR) begin
         sx_ff  <= sx_in;
         sx2_ff <= sx2_in;
         bx2_ff <= bx2_in;
         cy2_ff <= cy2_in;
      end
      if (state_ff == F_PART) begin
         q_ff      <= q_in;
         qs_neg_ff <= qs_neg_in;
         qs_hi_ff  <= qs_hi_in;
         plo_ff    <= plo_in;
         bulb_ff   <= bulb_in;
      end
   end

endmodule

// ===== rtl/metu_queue.sv =====
module metu_queue
   import metu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     valid,
   output work_type pop_data
);

   work_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== rtl/metu_core.sv =====
module metu_core
   import metu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     work_valid,
   input  work_type work_data,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam int NW = 40;  // normalizer width, covers |z|^2 and the first log

   typedef enum logic [2:0] {C_IDLE, C_ITER, C_NORM, C_LOG, C_HOLD} state_type;

   state_type          state_ff, state_in;
   logic signed [31:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [33:0] zx_ff, zx_in, zy_ff, zy_in;
   logic [15:0]        count_ff, count_in;
   logic [NW-1:0]      x_ff, x_in;
   logic [5:0]         sh_ff, sh_in;
   logic [2:0]         step_ff, step_in;
   logic               pass_ff, pass_in;
   rsp_type            res_ff, res_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_data_ff, out_data_in;

   logic [33:0]        mzx, mzy;
   logic [67:0]        pr_xx, pr_yy, pr_xy;
   logic [39:0]        pxx, pyy;
   logic signed [40:0] pxy;
   logic [40:0]        sum;
   logic signed [41:0] zx_next, zy_next;
   logic               top_zero;
   logic [5:0]         k;
   logic signed [7:0]  expo;
   logic signed [24:0] lg;
   logic signed [34:0] val;
   logic signed [26:0] val_q8;

   assign mzx   = zx_ff[33] ? 34'(-zx_ff) : 34'(zx_ff);
   assign mzy   = zy_ff[33] ? 34'(-zy_ff) : 34'(zy_ff);
   assign pr_xx = 68'(mzx) * 68'(mzx);
   assign pr_yy = 68'(mzy) * 68'(mzy);
   assign pr_xy = 68'(mzx) * 68'(mzy);
   assign pxx   = pr_xx[67:28];
   assign pyy   = pr_yy[67:28];
   assign pxy   = (zx_ff[33] ^ zy_ff[33]) ? -$signed({1'b0, pr_xy[67:28]})
                                           : $signed({1'b0, pr_xy[67:28]});
   assign sum   = 41'(pxx) + 41'(pyy);
   assign zy_next = {pxy, 1'b0} + 42'(cy_ff);
   assign zx_next = $signed({2'b00, pxx}) - $signed({2'b00, pyy}) + 42'(cx_ff);

   // binary search for the leading one, largest shift first
   always_comb begin
      unique case (step_ff)
         3'd0: begin k = 6'd32; top_zero = (x_ff[NW-1 -: 32] == '0); end
         3'd1: begin k = 6'd16; top_zero = (x_ff[NW-1 -: 16] == '0); end
         3'd2: begin k = 6'd8;  top_zero = (x_ff[NW-1 -: 8] == '0);  end
         3'd3: begin k = 6'd4;  top_zero = (x_ff[NW-1 -: 4] == '0);  end
         3'd4: begin k = 6'd2;  top_zero = (x_ff[NW-1 -: 2] == '0);  end
         default: begin k = 6'd1; top_zero = !x_ff[NW-1]; end
      endcase
   end

   assign expo   = 8'(NW - 1) - 8'(sh_ff) - (pass_ff ? 8'd16 : 8'(COORD_FRAC_BITS));
   assign lg     = {expo[7], expo, 16'h0000}
                 + 25'(LOG_TABLE[x_ff[NW-2 -: LOG_TABLE_BITS]]);
   assign val    = $signed({3'b000, count_ff, 16'h0000}) + 35'(SMOOTH_BIAS_Q16) - 35'(lg);
   assign val_q8 = val[34:8];

   assign pop       = (state_ff == C_IDLE) && work_valid;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      state_in     = state_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      zx_in        = zx_ff;
      zy_in        = zy_ff;
      count_in     = count_ff;
      x_in         = x_ff;
      sh_in        = sh_ff;
      step_in      = step_ff;
      pass_in      = pass_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_data_in  = out_data_ff;
      unique case (state_ff)
         C_IDLE: if (work_valid) begin
            cx_in    = work_data.cx;
            cy_in    = work_data.cy;
            zx_in    = '0;
            zy_in    = '0;
            count_in = '0;
            if (work_data.shortcut) begin
               res_in   = '{smooth_value: '0, escape_count: '0, in_set: 1'b1,
                            by_shortcut: 1'b1};
               state_in = C_HOLD;
            end else begin
               state_in = C_ITER;
            end
         end
         C_ITER: begin
            if (count_ff == cfg.iteration_limit) begin
               res_in   = '{smooth_value: '0, escape_count: count_ff, in_set: 1'b1,
                            by_shortcut: 1'b0};
               state_in = C_HOLD;
            end else if (sum >= 41'(64'd4 << COORD_FRAC_BITS)) begin
               x_in     = sum[NW-1:0];
               sh_in    = '0;
               step_in  = '0;
               pass_in  = 1'b0;
               state_in = C_NORM;
            end else begin
               zx_in    = zx_next[33:0];
               zy_in    = zy_next[33:0];
               count_in = count_ff + 16'd1;
            end
         end
         C_NORM: begin
            if (top_zero) begin
               x_in  = x_ff << k;
               sh_in = sh_ff + k;
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd5) state_in = C_LOG;
         end
         C_LOG: begin
            if (!pass_ff) begin
               // first log is positive since |z|^2 >= 4
               x_in     = NW'(lg[23:0]);
               sh_in    = '0;
               step_in  = '0;
               pass_in  = 1'b1;
               state_in = C_NORM;
            end else begin
               res_in.escape_count = count_ff;
               res_in.in_set       = 1'b0;
               res_in.by_shortcut  = 1'b0;
               if (val <= 0)
                  res_in.smooth_value = '0;
               else if (val_q8 > 27'sh0FFFFFF)
                  res_in.smooth_value = 24'hFFFFFF;
               else
                  res_in.smooth_value = val_q8[23:0];
               state_in = C_HOLD;
            end
         end
         C_HOLD: if (!out_valid_ff || !rsp_stall) begin
            out_valid_in = 1'b1;
            out_data_in  = res_ff;
            state_in     = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      zx_ff       <= zx_in;
      zy_ff       <= zy_in;
      count_ff    <= count_in;
      x_ff        <= x_in;
      sh_ff       <= sh_in;
      step_ff     <= step_in;
      pass_ff     <= pass_in;
      res_ff      <= res_in;
      out_data_ff <= out_data_in;
   end

endmodule

// ===== rtl/mandelbrot_escape_time_unit.sv =====
// Mandelbrot escape-time evaluator with smooth coloring, one result beat per request beat,
// in order. The front stage maps column/row to c in Q4.28 and runs the cardioid and bulb
// test, taking a new request only once it has pushed the last pixel into the two-entry queue
// that feeds the iteration core. The core does one z = z^2 + c step per cycle on a 34-bit
// datapath; a pixel that escapes goes through the iteration steps, two leading-one searches
// each followed by a table lookup, and a step each to load and to hand off. A pixel that
// hits the limit L or is caught by the shortcut test skips the searches. The iteration loop
// sets the throughput. Registers may be written only while no pixel is in flight.
module mandelbrot_escape_time_unit
   import metu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   cfg_type  cfg_ff, cfg_in;
   logic     push, queue_full, pop, work_valid;
   work_type push_data, work_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_X_ORIGIN: cfg_in.x_origin        = csr_data;
            CSR_X_STEP:   cfg_in.x_step          = csr_data;
            CSR_Y_ORIGIN: cfg_in.y_origin        = csr_data;
            CSR_Y_STEP:   cfg_in.y_step          = csr_data;
            CSR_LIMIT:    cfg_in.iteration_limit = csr_data[15:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{x_origin: 32'shE0000000, x_step: 32'sd786432,
                     y_origin: 32'shE8000000, y_step: 32'sd786432,
                     iteration_limit: 16'd256};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   metu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   metu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .valid     (work_valid),
      .pop_data  (work_data)
   );

   metu_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .work_valid (work_valid),
      .work_data  (work_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   a_shortcut_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.by_shortcut |-> rsp_data.in_set && rsp_data.escape_count == 16'd0)
      else $error("shortcut result with nonzero count or not in set");

   a_in_set_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.in_set |-> rsp_data.smooth_value == 24'd0)
      else $error("in-set result carries a smooth value");

   a_escape_below_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.in_set |-> rsp_data.escape_count < cfg_ff.iteration_limit)
      else $error("escaped result at or past the iteration limit");

endmodule

// ===== dv/mandelbrot_escape_time_unit_tb.sv =====
`timescale 1ns / 100ps

module mandelbrot_escape_time_unit_tb;
   import metu_pkg::*;

   localparam int  TIMEOUT_CYCLES = 3000000;
   localparam int  DRAIN_CYCLES   = 40;
   localparam int  RX_HOLD_CYCLES = 3000;
   localparam logic [63:0] FOUR_Q = 64'd4 << COORD_FRAC_BITS;
   localparam logic signed [63:0] ONE_Q = 64'sd1 <<< COORD_FRAC_BITS;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b1;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_X_ORIGIN;
   logic [31:0]            csr_data = '0;

   mandelbrot_escape_time_unit DUT (.*);

   always #5 clock = ~clock;

   cfg_type   view_cfg;
   req_type   pixel_q[$];
   rsp_type   pixel_result_q[$];
   bit        burst_mode = 1'b0;
   int        error_count = 0;
   int        cycle_count = 0;

   // ---------------- pixel predictor ----------------
   function automatic logic [63:0] abs64(logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   // exact product shifted down by the fraction bits, saturated
   function automatic logic [63:0] qmul_u(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      if ((p >> (64 + COORD_FRAC_BITS)) != 0) return '1;
      return 64'(p >> COORD_FRAC_BITS);
   endfunction

   function automatic logic signed [63:0] qmul_s(logic signed [63:0] a, logic signed [63:0] b);
      logic [63:0] r;
      r = qmul_u(abs64(a), abs64(b));
      if (r > 64'h7FFF_FFFF_FFFF_FFFF) r = 64'h7FFF_FFFF_FFFF_FFFF;
      return (a[63] != b[63]) ? -$signed(r) : $signed(r);
   endfunction

   function automatic longint mantissa_log(int idx);
      logic [63:0] y;
      longint      r;
      y = (64'd1 << 30) + (64'(idx) << (30 - LOG_TABLE_BITS));
      r = 0;
      for (int k = 0; k < 16; k++) begin
         y = (y * y) >> 30;
         r = r * 2;
         if (y >= (64'd2 << 30)) begin
            y = y >> 1;
            r = r + 1;
         end
      end
      return r;
   endfunction

   function automatic longint log2_q16(logic [63:0] x, int fbits);
      int          msb;
      logic [63:0] idx;
      if (x == 0) return 0;
      msb = 63;
      while (x[msb] == 1'b0) msb--;
      if (msb >= LOG_TABLE_BITS) idx = x >> (msb - LOG_TABLE_BITS);
      else idx = x << (LOG_TABLE_BITS - msb);
      idx = idx & ((64'd1 << LOG_TABLE_BITS) - 1);
      return longint'(msb - fbits) * 65536 + mantissa_log(int'(idx));
   endfunction

   function automatic logic signed [63:0] pixel_coord(logic signed [31:0] origin,
                                                      logic signed [31:0] step,
                                                      logic [11:0] idx);
      longint c;
      c = longint'(origin) + longint'({52'd0, idx}) * longint'(step);
      if (c > 64'sh7FFF_FFFF) c = 64'sh7FFF_FFFF;
      if (c < -64'sh8000_0000) c = -64'sh8000_0000;
      return c;
   endfunction

   function automatic rsp_type predict_pixel(req_type px, cfg_type cfg);
      rsp_type            res;
      logic signed [63:0] cx, cy, sx, bx, qs, zx, zy;
      logic [63:0]        cy2, q, zx2, zy2, sum;
      bit                 card, bulb;
      int                 count;
      longint             l1, l2, val;
      cx  = pixel_coord(cfg.x_origin, cfg.x_step, px.column);
      cy  = pixel_coord(cfg.y_origin, cfg.y_step, px.row);
      sx  = cx - ONE_Q / 4;
      bx  = cx + ONE_Q;
      cy2 = qmul_u(abs64(cy), abs64(cy));
      q   = qmul_u(abs64(sx), abs64(sx)) + cy2;
      qs  = $signed(q) + sx;
      card = qs[63] || (qmul_u(q, qs) <= (cy2 >> 2));
      bulb = (qmul_u(abs64(bx), abs64(bx)) + cy2) <= (64'd1 << (COORD_FRAC_BITS - 4));
      res = '0;
      res.in_set = 1'b1;
      if (card || bulb) begin
         res.by_shortcut = 1'b1;
         return res;
      end
      zx = 0; zy = 0; zx2 = 0; zy2 = 0; sum = 0; count = 0;
      while (sum < FOUR_Q && count < int'(cfg.iteration_limit)) begin
         zy  = 2 * qmul_s(zx, zy) + cy;
         zx  = $signed(zx2) - $signed(zy2) + cx;
         zx2 = qmul_u(abs64(zx), abs64(zx));
         zy2 = qmul_u(abs64(zy), abs64(zy));
         sum = zx2 + zy2;
         if (sum < zx2) sum = '1;
         count++;
      end
      res.escape_count = 16'(count);
      if (count == int'(cfg.iteration_limit)) return res;
      l1  = log2_q16(sum, COORD_FRAC_BITS);
      l2  = log2_q16(64'(l1), 16);
      val = longint'(count) * 65536 + SMOOTH_BIAS_Q16 - l2;
      if (val <= 0) val = 0;
      else begin
         val = val / 256;
         if (val > 64'hFF_FFFF) val = 64'hFF_FFFF;
      end
      res.smooth_value = 24'(val);
      res.in_set = 1'b0;
      return res;
   endfunction

   // ---------------- request driver ----------------
   int tx_gap = 0;

   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            pixel_result_q.push_back(predict_pixel(req_data, view_cfg));
         if (!req_valid || !req_stall) begin
            next_valid = 1'b0;
            if (tx_gap > 0) begin
               tx_gap--;
            end else if (pixel_q.size() > 0) begin
               req_data  <= pixel_q.pop_front();
               next_valid = 1'b1;
               tx_gap     = burst_mode ? 0 : $urandom_range(0, 13);
            end
         end else begin
            next_valid = 1'b1;
         end
         req_valid <= next_valid;
      end
   end

   // ---------------- result monitor ----------------
   int rx_gap = 0;
   int rx_hold = 0;
   int rx_beats = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rx_beats++;
            if (pixel_result_q.size() == 0) begin
               $error("unexpected result beat %p", rsp_data);
               error_count++;
            end else begin
               want = pixel_result_q.pop_front();
               if (rsp_data.smooth_value !== want.smooth_value) begin
                  $error("smooth_value: expected %0d, actual %0d",
                         want.smooth_value, rsp_data.smooth_value);
                  error_count++;
               end
               if (rsp_data.escape_count !== want.escape_count) begin
                  $error("escape_count: expected %0d, actual %0d",
                         want.escape_count, rsp_data.escape_count);
                  error_count++;
               end
               if (rsp_data.in_set !== want.in_set) begin
                  $error("in_set: expected %0d, actual %0d", want.in_set, rsp_data.in_set);
                  error_count++;
               end
               if (rsp_data.by_shortcut !== want.by_shortcut) begin
                  $error("by_shortcut: expected %0d, actual %0d",
                         want.by_shortcut, rsp_data.by_shortcut);
                  error_count++;
               end
            end
            rx_gap = burst_mode ? 0 : $urandom_range(0, 13);
            // long back-pressure once, so the core and its input queue fill up
            if (rx_beats == 30) rx_hold = RX_HOLD_CYCLES;
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_stall <= 1'b1;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("mandelbrot_escape_time_unit: mismatch");
         $finish;
      end
   end

   // ---------------- sequencing ----------------
   task automatic wait_drained();
      while (pixel_q.size() > 0 || req_valid || pixel_result_q.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // back to back writes keep valid high; set_view drops it after the last beat
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_X_ORIGIN: view_cfg.x_origin = val;
         CSR_X_STEP:   view_cfg.x_step = val;
         CSR_Y_ORIGIN: view_cfg.y_origin = val;
         CSR_Y_STEP:   view_cfg.y_step = val;
         CSR_LIMIT:    view_cfg.iteration_limit = val[15:0];
         default: ;
      endcase
   endtask

   task automatic set_view(logic [31:0] x0, logic [31:0] xs, logic [31:0] y0,
                           logic [31:0] ys, logic [15:0] lim);
      write_reg(CSR_X_ORIGIN, x0);
      write_reg(CSR_X_STEP, xs);
      write_reg(CSR_Y_ORIGIN, y0);
      write_reg(CSR_Y_STEP, ys);
      write_reg(CSR_LIMIT, {16'd0, lim});
      csr_valid <= 1'b0;
   endtask

   task automatic add_pixel(int col, int row);
      req_type px;
      px.column = col[11:0];
      px.row    = row[11:0];
      pixel_q.push_back(px);
   endtask

   task automatic add_random(int n, int max_idx);
      repeat (n) add_pixel($urandom_range(0, max_idx), $urandom_range(0, max_idx));
   endtask

   initial begin
      view_cfg.x_origin        = -32'sd536870912;
      view_cfg.x_step          = 32'sd786432;
      view_cfg.y_origin        = -32'sd402653184;
      view_cfg.y_step          = 32'sd786432;
      view_cfg.iteration_limit = 16'd256;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset view: corners, cardioid, period-two bulb, quick escape
      add_pixel(0, 0);
      add_pixel(4095, 4095);
      add_pixel(0, 4095);
      add_pixel(4095, 0);
      add_pixel(683, 512);
      add_pixel(341, 512);
      add_pixel(100, 900);
      add_pixel(600, 300);
      burst_mode = 1'b1;
      add_random(60, 1023);
      wait_drained();
      burst_mode = 1'b0;
      add_random(60, 1023);
      wait_drained();

      // register extremes: coordinates saturate, limit of one
      set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'd1);
      add_pixel(0, 0);
      add_pixel(4095, 4095);
      add_pixel(1, 1);
      add_pixel(0, 4095);
      add_random(30, 4095);
      wait_drained();

      // largest limit: one pixel near the period-four bulb stays in, the rest escape
      set_view(32'd536870912, -32'sd1048576, 32'd0, 32'd0, 16'd65535);
      add_pixel(843, 7);
      add_pixel(0, 4095);
      add_random(6, 60);
      wait_drained();

      // random views: mostly windows on the set, some raw register values
      for (int ph = 0; ph < 6; ph++) begin
         if (ph % 3 == 2)
            set_view($urandom, $urandom, $urandom, $urandom,
                     16'($urandom_range(1, 300)));
         else
            set_view(-$urandom_range(32'd134217728, 32'd671088640),
                     $urandom_range(32'd4096, 32'd1048576),
                     -$urandom_range(0, 32'd402653184),
                     $urandom_range(32'd4096, 32'd1048576),
                     16'($urandom_range(1, 400)));
         burst_mode = (ph == 3);
         add_random(48, (ph % 2) ? 4095 : 1023);
         wait_drained();
      end

      if (error_count == 0) begin
         $display("mandelbrot_escape_time_unit: match");
      end else begin
         $display("mandelbrot_escape_time_unit: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/metu_pkg.sv
rtl/metu_front.sv
rtl/metu_queue.sv
rtl/metu_core.sv
rtl/mandelbrot_escape_time_unit.sv
dv/mandelbrot_escape_time_unit_tb.sv
